@@ hw/rtl/ecseq_pkg.sv @@
// shared types, codes and result helpers for the ec host transaction sequencer
package ecseq_pkg;

    localparam int OQ_DEPTH = 4;

    localparam logic [15:0] POLL_LIMIT_RST = 16'd1000;

    localparam logic [7:0] IBF_MASK  = 8'h02;
    localparam logic [7:0] OBF_MASK  = 8'h01;
    localparam logic [7:0] CMD_PORT  = 8'h66;
    localparam logic [7:0] DATA_PORT = 8'h62;
    localparam logic [7:0] READ_CMD  = 8'h80;
    localparam logic [7:0] WRITE_CMD = 8'h81;

    typedef enum logic [1:0] {
        FUNC_READ   = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_ANSWER = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ACT_PORT_RD = 2'd0,
        ACT_PORT_WR = 2'd1,
        ACT_DONE    = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_IN_TIMEOUT = 3'd1,
        ST_NO_DATA    = 3'd2,
        ST_FOREIGN    = 3'd3,
        ST_UNCLEAR    = 3'd4,
        ST_BUSY       = 3'd5
    } t_status;

    typedef enum logic [13:0] {
        PH_IDLE   = 14'b00000000000001,
        PH_R_IBC1 = 14'b00000000000010,
        PH_R_OBE  = 14'b00000000000100,
        PH_R_IBC2 = 14'b00000000001000,
        PH_R_OBF  = 14'b00000000010000,
        PH_R_DATA = 14'b00000000100000,
        PH_W_IBC1 = 14'b00000001000000,
        PH_W_OBE1 = 14'b00000010000000,
        PH_W_IBC2 = 14'b00000100000000,
        PH_W_OBE2 = 14'b00001000000000,
        PH_W_IBC3 = 14'b00010000000000,
        PH_W_OBE3 = 14'b00100000000000,
        PH_W_IBC4 = 14'b01000000000000,
        PH_W_OBE4 = 14'b10000000000000
    } t_phase;

    typedef struct packed {
        t_action     action;
        logic [7:0]  port_number;
        logic [7:0]  byte_value;
        t_status     status;
        logic        last;
    } t_result;

    // words produced by one accepted item, count is 0 to 2
    typedef struct packed {
        logic [1:0] count;
        t_result    w0;
        t_result    w1;
    } t_push;

    function automatic t_result f_result(t_action act, logic [7:0] port,
                                         logic [7:0] val, t_status st, logic lst);
        t_result r;
        r.action      = act;
        r.port_number = port;
        r.byte_value  = val;
        r.status      = st;
        r.last        = lst;
        return r;
    endfunction

endpackage

@@ hw/rtl/ecseq_core.sv @@
// transaction state, poll counter and per-item step logic
module ecseq_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_step,
    input  logic [1:0]         i_func,
    input  logic [7:0]         i_reg_address,
    input  logic [7:0]         i_write_byte,
    input  logic [7:0]         i_port_answer,
    output ecseq_pkg::t_push   o_push
);
    import ecseq_pkg::*;

    logic [15:0] r_poll_limit;
    t_phase      r_phase,        n_phase;
    logic [15:0] r_poll_count,   n_poll_count;
    logic [7:0]  r_held_address, n_held_address;
    logic [7:0]  r_held_data,    n_held_data;
    logic        r_write_begun,  n_write_begun;

    logic [15:0] limit;
    logic [15:0] cnt_inc;
    logic        flag_ok;
    t_status     fail_st;
    t_phase      nxt;
    logic        wr_en;
    logic [7:0]  wr_port;
    logic [7:0]  wr_val;
    t_push       push;
    t_result     poll_word;

    assign limit     = (r_poll_limit == 16'd0) ? 16'd1 : r_poll_limit;
    assign cnt_inc   = (r_poll_count == 16'hFFFF) ? r_poll_count : r_poll_count + 16'd1;
    assign poll_word = f_result(ACT_PORT_RD, CMD_PORT, 8'd0, ST_OK, 1'b1);

    // which flag the current wait looks for
    always_comb begin
        case (r_phase)
            PH_R_IBC1, PH_R_IBC2, PH_W_IBC1, PH_W_IBC2, PH_W_IBC3, PH_W_IBC4: begin
                flag_ok = (i_port_answer & IBF_MASK) == 8'd0;
                fail_st = ST_IN_TIMEOUT;
            end
            PH_R_OBF: begin
                flag_ok = (i_port_answer & OBF_MASK) != 8'd0;
                fail_st = ST_NO_DATA;
            end
            default: begin
                flag_ok = (i_port_answer & OBF_MASK) == 8'd0;
                fail_st = ST_FOREIGN;
            end
        endcase
    end

    // successor phase and the optional port write that precedes the next poll
    always_comb begin
        nxt     = PH_IDLE;
        wr_en   = 1'b0;
        wr_port = CMD_PORT;
        wr_val  = 8'd0;
        case (r_phase)
            PH_R_IBC1: nxt = PH_R_OBE;
            PH_R_OBE: begin
                nxt    = PH_R_IBC2;
                wr_en  = 1'b1;
                wr_val = READ_CMD;
            end
            PH_R_IBC2: begin
                nxt     = PH_R_OBF;
                wr_en   = 1'b1;
                wr_port = DATA_PORT;
                wr_val  = r_held_address;
            end
            PH_W_IBC1: nxt = PH_W_OBE1;
            PH_W_OBE1: begin
                nxt    = PH_W_IBC2;
                wr_en  = 1'b1;
                wr_val = WRITE_CMD;
            end
            PH_W_IBC2: nxt = PH_W_OBE2;
            PH_W_OBE2: begin
                nxt     = PH_W_IBC3;
                wr_en   = 1'b1;
                wr_port = DATA_PORT;
                wr_val  = r_held_address;
            end
            PH_W_IBC3: nxt = PH_W_OBE3;
            PH_W_OBE3: begin
                nxt     = PH_W_IBC4;
                wr_en   = 1'b1;
                wr_port = DATA_PORT;
                wr_val  = r_held_data;
            end
            PH_W_IBC4: nxt = PH_W_OBE4;
            default:   nxt = PH_IDLE;
        endcase
    end

    always_comb begin
        n_phase        = r_phase;
        n_poll_count   = r_poll_count;
        n_held_address = r_held_address;
        n_held_data    = r_held_data;
        n_write_begun  = r_write_begun;
        push           = '0;
        if (i_step) begin
            if (i_func == FUNC_READ || i_func == FUNC_WRITE) begin
                push.count = 2'd1;
                if (r_phase != PH_IDLE) begin
                    push.w0 = f_result(ACT_DONE, 8'd0, 8'd0, ST_BUSY, 1'b1);
                end else begin
                    push.w0        = poll_word;
                    n_held_address = i_reg_address;
                    n_held_data    = (i_func == FUNC_WRITE) ? i_write_byte : 8'd0;
                    n_write_begun  = 1'b0;
                    n_poll_count   = 16'd0;
                    n_phase        = (i_func == FUNC_WRITE) ? PH_W_IBC1 : PH_R_IBC1;
                end
            end else if (i_func == FUNC_ANSWER && r_phase != PH_IDLE) begin
                push.count = 2'd1;
                if (r_phase == PH_R_DATA) begin
                    push.w0       = f_result(ACT_DONE, 8'd0, i_port_answer, ST_OK, 1'b1);
                    n_phase       = PH_IDLE;
                    n_poll_count  = 16'd0;
                    n_write_begun = 1'b0;
                end else if (!flag_ok) begin
                    if (cnt_inc >= limit) begin
                        push.w0 = f_result(ACT_DONE, 8'd0, 8'd0,
                                           r_write_begun ? ST_UNCLEAR : fail_st, 1'b1);
                        n_phase       = PH_IDLE;
                        n_poll_count  = 16'd0;
                        n_write_begun = 1'b0;
                    end else begin
                        push.w0      = poll_word;
                        n_poll_count = cnt_inc;
                    end
                end else if (r_phase == PH_W_OBE4) begin
                    push.w0       = f_result(ACT_DONE, 8'd0, 8'd0, ST_OK, 1'b1);
                    n_phase       = PH_IDLE;
                    n_poll_count  = 16'd0;
                    n_write_begun = 1'b0;
                end else if (r_phase == PH_R_OBF) begin
                    // output buffer full: fetch the data byte
                    push.w0      = f_result(ACT_PORT_RD, DATA_PORT, 8'd0, ST_OK, 1'b1);
                    n_phase      = PH_R_DATA;
                    n_poll_count = 16'd0;
                end else begin
                    n_phase      = nxt;
                    n_poll_count = 16'd0;
                    if (r_phase == PH_W_OBE1) begin
                        n_write_begun = 1'b1;
                    end
                    if (wr_en) begin
                        push.count = 2'd2;
                        push.w0    = f_result(ACT_PORT_WR, wr_port, wr_val, ST_OK, 1'b0);
                        push.w1    = poll_word;
                    end else begin
                        push.w0 = poll_word;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit   <= POLL_LIMIT_RST;
            r_phase        <= PH_IDLE;
            r_poll_count   <= 16'd0;
            r_held_address <= 8'd0;
            r_held_data    <= 8'd0;
            r_write_begun  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_poll_limit <= i_cfg_data;
            end
            r_phase        <= n_phase;
            r_poll_count   <= n_poll_count;
            r_held_address <= n_held_address;
            r_held_data    <= n_held_data;
            r_write_begun  <= n_write_begun;
        end
    end

    assign o_push = push;

endmodule

@@ hw/rtl/ecseq_outq.sv @@
// result queue, takes up to two words a cycle and hands out one
module ecseq_outq #(
    parameter int Depth = ecseq_pkg::OQ_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ecseq_pkg::t_push    i_push,
    input  logic                i_pop,
    output ecseq_pkg::t_result  o_head,
    output logic                o_valid,
    output logic                o_room
);
    import ecseq_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

    t_result         r_mem [Depth];
    logic [PtrW-1:0] r_wp,  n_wp;
    logic [PtrW-1:0] r_rp,  n_rp;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [PtrW-1:0] wp1;
    logic            pop_ok;

    function automatic logic [PtrW-1:0] f_inc(logic [PtrW-1:0] p);
        return (p == LastIdx) ? '0 : p + PtrW'(1);
    endfunction

    assign wp1    = f_inc(r_wp);
    assign pop_ok = i_pop && (r_cnt != '0);

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        if (i_push.count == 2'd1) begin
            n_wp = wp1;
        end else if (i_push.count == 2'd2) begin
            n_wp = f_inc(wp1);
        end
        if (pop_ok) begin
            n_rp = f_inc(r_rp);
        end
        n_cnt = r_cnt + CntW'(i_push.count) - CntW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.w0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wp1] <= i_push.w1;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_valid = (r_cnt != '0);
    // room for the two words one item can produce
    assign o_room  = (r_cnt <= CntW'(Depth - 2));

endmodule

@@ hw/rtl/acpi_ec_host_transaction_sequencer.sv @@
// top level of the ec host transaction sequencer
//
// Runs the host side of one embedded-controller byte read or write. A request word
// (func read or write) starts a transaction; the block answers with port access
// words (read or write on command/status port 0x66 or data port 0x62), and every
// requested port read is answered by a later input word with func answer.
// A finished word carries the status and, for a good read, the data byte.
// The config channel writes the 16-bit poll limit (reset 1000, zero acts as one),
// the number of status reads allowed per wait; write it only while idle.
// Result words of an accepted item are registered in the queue, behind any earlier words.
// Throughput: one input word per cycle while the queue has room, if each yields one
// result word; an item that sends a port write plus the next poll makes two words,
// and the output side delivers one word per cycle while the receiver is ready.
// A small result queue sits between the sides: input is taken while it has room
// for two words, so a stalled receiver blocks input once fewer than two entries are free.
// Reset (synchronous, active low) clears the queue, returns to idle and restores
// the poll limit to 1000.
module acpi_ec_host_transaction_sequencer #(
    parameter int QueueDepth = ecseq_pkg::OQ_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_reg_address,
    input  logic [7:0]  i_write_byte,
    input  logic [7:0]  i_port_answer,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_action,
    output logic [7:0]  o_port_number,
    output logic [7:0]  o_byte_value,
    output logic [2:0]  o_status,
    output logic        o_last
);
    import ecseq_pkg::*;

    t_push   push;
    t_result head;
    logic    room;
    logic    step;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = room;
    assign step        = i_in_valid && room;

    ecseq_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_step        (step),
        .i_func        (i_func),
        .i_reg_address (i_reg_address),
        .i_write_byte  (i_write_byte),
        .i_port_answer (i_port_answer),
        .o_push        (push)
    );

    ecseq_outq #(
        .Depth (QueueDepth)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_out_ready),
        .o_head  (head),
        .o_valid (o_out_valid),
        .o_room  (room)
    );

    assign o_action      = head.action;
    assign o_port_number = head.port_number;
    assign o_byte_value  = head.byte_value;
    assign o_status      = head.status;
    assign o_last        = head.last;

    // words appear only for an accepted item
    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count != 2'd0) |-> (i_in_valid && o_in_ready))
        else $error("result words produced without an accepted item");

    // a write-then-poll pair: only the second word closes the item
    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count == 2'd2) |-> (!push.w0.last && push.w1.last
                                  && push.w0.action == ACT_PORT_WR))
        else $error("bad last marking on a two-word item");

    // a finished word always closes its item
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == ACT_DONE) |-> o_last)
        else $error("finished word without last");

    // port accesses never carry a failure status
    a_port_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action != ACT_DONE) |-> (o_status == ST_OK))
        else $error("port access word with nonzero status");

endmodule
